// ----- src/svgf_pkg.sv -----
// Shared types, codes and helpers of the SVG path segment flattener.
package svgf_pkg;

   localparam int COORD_W = 24;
   localparam int ACC_W   = 48;
   localparam int U_W     = 44;
   localparam int UL_W    = 22;
   localparam int ML_W    = 23;
   localparam int M_W     = 45;
   localparam int PP_W    = UL_W + ML_W;
   localparam int PROD_W  = U_W + M_W;
   localparam int Q_W     = 26;

   localparam logic [3:0] CMD_MOVE   = 4'd0;
   localparam logic [3:0] CMD_LINE   = 4'd1;
   localparam logic [3:0] CMD_HORIZ  = 4'd2;
   localparam logic [3:0] CMD_VERT   = 4'd3;
   localparam logic [3:0] CMD_CUBIC  = 4'd4;
   localparam logic [3:0] CMD_SCUBIC = 4'd5;
   localparam logic [3:0] CMD_QUAD   = 4'd6;
   localparam logic [3:0] CMD_SQUAD  = 4'd7;
   localparam logic [3:0] CMD_CLOSE  = 4'd8;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_CUBIC = 2'd1;
   localparam logic [1:0] KIND_QUAD  = 2'd2;

   localparam logic [1:0] DEG_LINE  = 2'd1;
   localparam logic [1:0] DEG_QUAD  = 2'd2;
   localparam logic [1:0] DEG_CUBIC = 2'd3;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      logic [1:0] deg;
      point_type  p0;
      point_type  p1;
      point_type  p2;
      point_type  p3;
   } seg_type;

   function automatic coord_type sat24(input logic signed [Q_W-1:0] v);
      coord_type r;
      if (v > $signed(Q_W'(24'h7fffff))) begin
         r = 24'sh7fffff;
      end else if (v < -$signed(Q_W'(24'h800000))) begin
         r = 24'sh800000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   function automatic coord_type add_sat(input coord_type a, input coord_type b);
      logic signed [Q_W-1:0] s;
      s = $signed({{2{a[COORD_W-1]}}, a}) + $signed({{2{b[COORD_W-1]}}, b});
      return sat24(s);
   endfunction

   function automatic coord_type reflect(input coord_type c, input coord_type l);
      logic signed [Q_W-1:0] s;
      s = $signed({c[COORD_W-1], c, 1'b0}) - $signed({{2{l[COORD_W-1]}}, l});
      return sat24(s);
   endfunction

endpackage

// ----- src/svg_path_segment_flattener_unit.sv -----
// Top level of the SVG path segment flattener.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  command, relative, ctrl1/ctrl2/end x,y
//   rsp      out        rsp_valid / rsp_ready  out_x, out_y, last
//
// A drawing segment yields STEPS+1 points from the forward-difference stepper,
// one per cycle while rsp is not stalled.
// A move updates only the front end's path state and yields no point.
// A point passes the queue, stepper, u, partial-product and output registers.
// Synchronous reset clears path state, queue and pipeline; no clearing pass.
// A stalled rsp freezes the sampler; the front end keeps taking requests
// until the two-entry queue is full.
module svg_path_segment_flattener_unit #(
   parameter int STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [3:0]          req_command,
   input  logic                req_relative,
   input  svgf_pkg::coord_type req_ctrl1_x,
   input  svgf_pkg::coord_type req_ctrl1_y,
   input  svgf_pkg::coord_type req_ctrl2_x,
   input  svgf_pkg::coord_type req_ctrl2_y,
   input  svgf_pkg::coord_type req_end_x,
   input  svgf_pkg::coord_type req_end_y,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output svgf_pkg::coord_type rsp_out_x,
   output svgf_pkg::coord_type rsp_out_y,
   output logic                rsp_last
);

   logic              push, pop, head_valid;
   svgf_pkg::seg_type push_seg, head_seg;

   svgf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_relative (req_relative),
      .req_ctrl1_x  (req_ctrl1_x),
      .req_ctrl1_y  (req_ctrl1_y),
      .req_ctrl2_x  (req_ctrl2_x),
      .req_ctrl2_y  (req_ctrl2_y),
      .req_end_x    (req_end_x),
      .req_end_y    (req_end_y),
      .push         (push),
      .push_seg     (push_seg)
   );

   svgf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_seg   (push_seg),
      .not_full   (req_ready),
      .head_valid (head_valid),
      .head_seg   (head_seg),
      .pop        (pop)
   );

   svgf_back #(
      .STEPS (STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_seg   (head_seg),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_out_x  (rsp_out_x),
      .rsp_out_y  (rsp_out_y),
      .rsp_last   (rsp_last)
   );

endmodule

// ----- src/svgf_front.sv -----
// Front end: resolves each request against the path state and classifies it.
module svgf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [3:0]          req_command,
   input  logic                req_relative,
   input  svgf_pkg::coord_type req_ctrl1_x,
   input  svgf_pkg::coord_type req_ctrl1_y,
   input  svgf_pkg::coord_type req_ctrl2_x,
   input  svgf_pkg::coord_type req_ctrl2_y,
   input  svgf_pkg::coord_type req_end_x,
   input  svgf_pkg::coord_type req_end_y,
   output logic                push,
   output svgf_pkg::seg_type   push_seg
);

   svgf_pkg::coord_type cur_x_ff, cur_y_ff, start_x_ff, start_y_ff;
   svgf_pkg::coord_type lctl_x_ff, lctl_y_ff;
   logic [1:0]          kind_ff;
   svgf_pkg::coord_type cur_x_in, cur_y_in, start_x_in, start_y_in;
   svgf_pkg::coord_type lctl_x_in, lctl_y_in;
   logic [1:0]          kind_in;

   svgf_pkg::coord_type ox, oy, c1x, c1y, c2x, c2y, ex, ey;
   logic                take;
   logic                seg_push;

   assign take = req_valid && req_ready;
   assign push = take && seg_push;

   always_comb begin
      ox  = req_relative ? cur_x_ff : '0;
      oy  = req_relative ? cur_y_ff : '0;
      c1x = svgf_pkg::add_sat(req_ctrl1_x, ox);
      c1y = svgf_pkg::add_sat(req_ctrl1_y, oy);
      c2x = svgf_pkg::add_sat(req_ctrl2_x, ox);
      c2y = svgf_pkg::add_sat(req_ctrl2_y, oy);
      ex  = svgf_pkg::add_sat(req_end_x, ox);
      ey  = svgf_pkg::add_sat(req_end_y, oy);

      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      lctl_x_in  = lctl_x_ff;
      lctl_y_in  = lctl_y_ff;
      kind_in    = kind_ff;
      seg_push   = 1'b0;
      push_seg.deg  = svgf_pkg::DEG_LINE;
      push_seg.p0.x = cur_x_ff;
      push_seg.p0.y = cur_y_ff;
      push_seg.p1   = '0;
      push_seg.p2   = '0;
      push_seg.p3   = '0;

      unique case (req_command) inside
         svgf_pkg::CMD_MOVE: begin
            cur_x_in   = ex;
            cur_y_in   = ey;
            start_x_in = ex;
            start_y_in = ey;
            kind_in    = svgf_pkg::KIND_NONE;
         end
         svgf_pkg::CMD_LINE, svgf_pkg::CMD_HORIZ, svgf_pkg::CMD_VERT,
         svgf_pkg::CMD_CLOSE: begin
            if (req_command == svgf_pkg::CMD_HORIZ) begin
               ey = cur_y_ff;
            end
            if (req_command == svgf_pkg::CMD_VERT) begin
               ex = cur_x_ff;
            end
            if (req_command == svgf_pkg::CMD_CLOSE) begin
               ex = start_x_ff;
               ey = start_y_ff;
            end
            seg_push      = 1'b1;
            push_seg.deg  = svgf_pkg::DEG_LINE;
            push_seg.p1.x = ex;
            push_seg.p1.y = ey;
            cur_x_in      = ex;
            cur_y_in      = ey;
            kind_in       = svgf_pkg::KIND_NONE;
         end
         svgf_pkg::CMD_CUBIC, svgf_pkg::CMD_SCUBIC: begin
            if (req_command == svgf_pkg::CMD_SCUBIC) begin
               if (kind_ff == svgf_pkg::KIND_CUBIC) begin
                  c1x = svgf_pkg::reflect(cur_x_ff, lctl_x_ff);
                  c1y = svgf_pkg::reflect(cur_y_ff, lctl_y_ff);
               end else begin
                  c1x = cur_x_ff;
                  c1y = cur_y_ff;
               end
            end
            seg_push      = 1'b1;
            push_seg.deg  = svgf_pkg::DEG_CUBIC;
            push_seg.p1.x = c1x;
            push_seg.p1.y = c1y;
            push_seg.p2.x = c2x;
            push_seg.p2.y = c2y;
            push_seg.p3.x = ex;
            push_seg.p3.y = ey;
            lctl_x_in     = c2x;
            lctl_y_in     = c2y;
            kind_in       = svgf_pkg::KIND_CUBIC;
            cur_x_in      = ex;
            cur_y_in      = ey;
         end
         svgf_pkg::CMD_QUAD, svgf_pkg::CMD_SQUAD: begin
            if (req_command == svgf_pkg::CMD_SQUAD) begin
               if (kind_ff == svgf_pkg::KIND_QUAD) begin
                  c1x = svgf_pkg::reflect(cur_x_ff, lctl_x_ff);
                  c1y = svgf_pkg::reflect(cur_y_ff, lctl_y_ff);
               end else begin
                  c1x = cur_x_ff;
                  c1y = cur_y_ff;
               end
            end
            seg_push      = 1'b1;
            push_seg.deg  = svgf_pkg::DEG_QUAD;
            push_seg.p1.x = c1x;
            push_seg.p1.y = c1y;
            push_seg.p2.x = ex;
            push_seg.p2.y = ey;
            lctl_x_in     = c1x;
            lctl_y_in     = c1y;
            kind_in       = svgf_pkg::KIND_QUAD;
            cur_x_in      = ex;
            cur_y_in      = ey;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         start_x_ff <= '0;
         start_y_ff <= '0;
         lctl_x_ff  <= '0;
         lctl_y_ff  <= '0;
         kind_ff    <= svgf_pkg::KIND_NONE;
      end else if (take) begin
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         lctl_x_ff  <= lctl_x_in;
         lctl_y_ff  <= lctl_y_in;
         kind_ff    <= kind_in;
      end
   end

endmodule

// ----- src/svgf_queue.sv -----
// Two-entry segment queue between the front end and the sampler.
module svgf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  svgf_pkg::seg_type push_seg,
   output logic              not_full,
   output logic              head_valid,
   output svgf_pkg::seg_type head_seg,
   input  logic              pop
);

   svgf_pkg::seg_type entries_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;

   assign not_full   = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_seg   = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_seg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

// ----- src/svgf_back.sv -----
// Sampler: forward-difference stepper and reciprocal divide pipeline.
module svgf_back #(
   parameter int STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  svgf_pkg::seg_type   head_seg,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output svgf_pkg::coord_type rsp_out_x,
   output svgf_pkg::coord_type rsp_out_y,
   output logic                rsp_last
);

   localparam int KW = $clog2(STEPS + 1);
   localparam longint unsigned DEN = longint'(STEPS) * STEPS * STEPS;
   localparam int SHL = $clog2(DEN);
   localparam int SH = svgf_pkg::U_W + SHL;
   localparam longint unsigned ONE = 1;
   localparam longint unsigned RECIP = ((ONE << SH) + DEN - 1) / DEN;
   localparam logic [svgf_pkg::M_W-1:0] RECIP_V = svgf_pkg::M_W'(RECIP);
   localparam logic [svgf_pkg::ML_W-1:0] RECIP_L = RECIP_V[svgf_pkg::ML_W-1:0];
   localparam logic [svgf_pkg::M_W-svgf_pkg::ML_W-1:0] RECIP_H =
      RECIP_V[svgf_pkg::M_W-1:svgf_pkg::ML_W];
   localparam longint BIAS = longint'(DEN / 2) + (longint'(DEN) << 24);
   localparam logic signed [svgf_pkg::ACC_W-1:0] BIAS_V = svgf_pkg::ACC_W'(BIAS);
   localparam logic signed [svgf_pkg::ACC_W-1:0] K0 = svgf_pkg::ACC_W'(DEN);
   localparam logic signed [svgf_pkg::ACC_W-1:0] KS2 =
      svgf_pkg::ACC_W'(longint'(STEPS) * STEPS);
   localparam logic signed [svgf_pkg::ACC_W-1:0] KS = svgf_pkg::ACC_W'(STEPS);
   localparam logic signed [svgf_pkg::Q_W-1:0] QOFF = svgf_pkg::Q_W'(24'h800000) <<< 1;

   typedef logic signed [svgf_pkg::ACC_W-1:0] acc_type;

   acc_type f0_ff [2];
   acc_type f1_ff [2];
   acc_type f2_ff [2];
   acc_type f3_ff [2];
   acc_type f0_in [2];
   acc_type f1_in [2];
   acc_type f2_in [2];
   acc_type f3_in [2];
   logic          busy_ff;
   logic [KW-1:0] k_ff;

   logic [svgf_pkg::U_W-1:0] u_ff [2];
   logic                     v1_ff, last1_ff;
   logic [svgf_pkg::PP_W-1:0] pp_ll_ff [2];
   logic [svgf_pkg::PP_W-1:0] pp_lh_ff [2];
   logic [svgf_pkg::PP_W-1:0] pp_hl_ff [2];
   logic [svgf_pkg::PP_W-1:0] pp_hh_ff [2];
   logic        v2_ff, last2_ff;
   logic        out_v_ff, out_last_ff;
   svgf_pkg::coord_type out_ff [2];

   logic    en, at_end, issue, load;
   acc_type p0 [2];
   acc_type p1 [2];
   acc_type p2 [2];
   acc_type p3 [2];
   acc_type k1, k2, c0, c1, c2, c3;
   acc_type sum_u [2];
   logic [svgf_pkg::PROD_W-1:0] prod [2];
   logic [svgf_pkg::PROD_W-1:0] quot [2];
   logic signed [svgf_pkg::Q_W-1:0] qs [2];

   assign en     = !out_v_ff || rsp_ready;
   assign at_end = (k_ff == KW'(STEPS));
   assign issue  = en && busy_ff;
   assign load   = en && head_valid && (!busy_ff || at_end);
   assign pop    = load;

   always_comb begin
      p0[0] = acc_type'(head_seg.p0.x);
      p1[0] = acc_type'(head_seg.p1.x);
      p2[0] = acc_type'(head_seg.p2.x);
      p3[0] = acc_type'(head_seg.p3.x);
      p0[1] = acc_type'(head_seg.p0.y);
      p1[1] = acc_type'(head_seg.p1.y);
      p2[1] = acc_type'(head_seg.p2.y);
      p3[1] = acc_type'(head_seg.p3.y);
      unique case (head_seg.deg)
         svgf_pkg::DEG_QUAD: begin
            k1 = KS2 <<< 1;
            k2 = KS;
         end
         svgf_pkg::DEG_CUBIC: begin
            k1 = KS2 * 3;
            k2 = KS * 3;
         end
         default: begin
            k1 = KS2;
            k2 = '0;
         end
      endcase
      for (int a = 0; a < 2; a++) begin
         c0 = p0[a] * K0;
         c1 = (p1[a] - p0[a]) * k1;
         c2 = (p0[a] - (p1[a] <<< 1) + p2[a]) * k2;
         c3 = (head_seg.deg == svgf_pkg::DEG_CUBIC) ?
              (p3[a] - p2[a] * 3 + p1[a] * 3 - p0[a]) : '0;
         if (load) begin
            f0_in[a] = c0;
            f1_in[a] = c1 + c2 + c3;
            f2_in[a] = (c2 <<< 1) + c3 * 6;
            f3_in[a] = c3 * 6;
         end else begin
            f0_in[a] = f0_ff[a] + f1_ff[a];
            f1_in[a] = f1_ff[a] + f2_ff[a];
            f2_in[a] = f2_ff[a] + f3_ff[a];
            f3_in[a] = f3_ff[a];
         end
         sum_u[a] = f0_ff[a] + BIAS_V;
         prod[a] = (svgf_pkg::PROD_W'(pp_hh_ff[a]) << (svgf_pkg::UL_W + svgf_pkg::ML_W))
                 + (svgf_pkg::PROD_W'(pp_hl_ff[a]) << svgf_pkg::UL_W)
                 + (svgf_pkg::PROD_W'(pp_lh_ff[a]) << svgf_pkg::ML_W)
                 + svgf_pkg::PROD_W'(pp_ll_ff[a]);
         quot[a] = prod[a] >> SH;
         qs[a] = $signed(quot[a][svgf_pkg::Q_W-1:0]) - QOFF;
      end
   end

   always_ff @(posedge clock) begin
      if (load || issue) begin
         for (int a = 0; a < 2; a++) begin
            f0_ff[a] <= f0_in[a];
            f1_ff[a] <= f1_in[a];
            f2_ff[a] <= f2_in[a];
            f3_ff[a] <= f3_in[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         k_ff    <= '0;
      end else if (issue) begin
         busy_ff <= !at_end;
         k_ff    <= k_ff + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         last1_ff    <= at_end;
         last2_ff    <= last1_ff;
         out_last_ff <= last2_ff;
         for (int a = 0; a < 2; a++) begin
            u_ff[a]     <= sum_u[a][svgf_pkg::U_W-1:0];
            pp_ll_ff[a] <= svgf_pkg::PP_W'(u_ff[a][svgf_pkg::UL_W-1:0] * RECIP_L);
            pp_lh_ff[a] <= svgf_pkg::PP_W'(u_ff[a][svgf_pkg::UL_W-1:0] * RECIP_H);
            pp_hl_ff[a] <= svgf_pkg::PP_W'(u_ff[a][svgf_pkg::U_W-1:svgf_pkg::UL_W] * RECIP_L);
            pp_hh_ff[a] <= svgf_pkg::PP_W'(u_ff[a][svgf_pkg::U_W-1:svgf_pkg::UL_W] * RECIP_H);
            out_ff[a]   <= svgf_pkg::sat24(qs[a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
         out_v_ff <= v2_ff;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_last  = out_last_ff;

endmodule

// ----- src/svgf_checker.sv -----
// Port-level checker for the SVG path segment flattener, bound to the top level.
module svgf_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input svgf_pkg::coord_type rsp_out_x,
   input svgf_pkg::coord_type rsp_out_y,
   input logic                rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
      $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req not ready right after reset");

endmodule

bind svg_path_segment_flattener_unit svgf_checker u_svgf_checker (.*);
